@@ rtl/sfd_pkg.sv @@
package sfd_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h24;
    localparam logic [7:0] TRL_BYTE   = 8'h25;
    localparam logic [7:0] TYPE_MOTOR = 8'hA5;
    localparam logic [7:0] TYPE_LOAD  = 8'hA6;

    // frame index of the first captured byte (the type byte)
    localparam int CAP_FIRST = 5;
    // last frame index a load cell record reads
    localparam int LOAD_LAST = 11;
    // data of a motor unit spans 25 bytes; its last byte lies 24 bytes after its start
    localparam int MOTOR_SPAN = 24;
    localparam int DATA_START = 6;

    localparam logic [14:0] MAX_LEN_RESET = 15'd10000;

    localparam logic [1:0] KIND_MOTOR  = 2'd0;
    localparam logic [1:0] KIND_LOAD   = 2'd1;
    localparam logic [1:0] KIND_NOTICE = 2'd2;

    localparam logic [3:0] MOTOR_LAST_FIELD = 4'd12;
    localparam logic [3:0] LOAD_LAST_FIELD  = 4'd3;

endpackage

@@ rtl/sfd_if.sv @@
interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_rec_if;
    logic               valid;
    logic               ready;
    logic [1:0]         record_kind;
    logic               unit_index;
    logic [3:0]         field_id;
    logic signed [31:0] field_value;
    logic               last_of_frame;

    modport source (output valid, output record_kind, output unit_index, output field_id,
                    output field_value, output last_of_frame, input ready);
    modport sink (input valid, input record_kind, input unit_index, input field_id,
                  input field_value, input last_of_frame, output ready);
endinterface

@@ rtl/status_frame_deframer_top.sv @@
// Body bytes of a frame are taken back to back, without leaving the idle state. Each header or
// length byte is followed by scan steps over the bytes held in the 4-byte window before another is taken.
// A good frame then emits its records, each byte read from the capture RAM (one write port, one read
// port) through a read state and an accumulate state; a record waits in the output register on receiver stalls.
// No input transaction is taken while records are being produced.
// Reset (rst_n low, asynchronous) returns to header hunting with max length 10000.
module status_frame_deframer_top #(
    parameter int MOTOR_UNITS  = 2,
    parameter int MOTOR_STRIDE = 35
) (
    input  logic        clk,
    input  logic        rst_n,
    sfd_rx_if.sink      rx,
    sfd_rec_if.source   rec,
    input  logic        cfg_we,
    input  logic [14:0] cfg_data
);

    localparam int CapLast  = sfd_pkg::DATA_START + (MOTOR_UNITS - 1) * MOTOR_STRIDE
                              + sfd_pkg::MOTOR_SPAN;
    localparam int CapDepth = CapLast - sfd_pkg::CAP_FIRST + 1;
    localparam int CapAw    = $clog2(CapDepth);
    localparam int OffW     = $clog2(CapLast + 4) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [14:0] bp_reg, bp_next;
    logic [14:0] len_reg, len_next;
    logic [7:0]  ft_reg, ft_next;
    logic [14:0] max_reg;
    logic [7:0]  rw_reg [2];
    logic [7:0]  rw_next [2];
    logic [7:0]  q_reg [4];
    logic [7:0]  q_next [4];
    logic [2:0]  n_reg, n_next;
    logic [1:0]  kind_reg, kind_next;
    logic        unit_reg, unit_next;
    logic [3:0]  fid_reg, fid_next;
    logic [1:0]  k_reg, k_next;
    logic [31:0] acc_reg, acc_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg;
    logic        out_unit_reg;
    logic [3:0]  out_fid_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;
    logic        out_load;

    logic             ram_we;
    logic [CapAw-1:0] ram_waddr;
    logic [CapAw-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    logic [OffW-1:0] base;
    logic [OffW-1:0] off;
    logic [1:0]      nb_m1;
    logic            rec_last;
    logic [31:0]     value;

    logic        accept;
    logic [15:0] widx;
    logic        body_end;
    logic [15:0] lenw;
    logic        len_bad;
    logic [1:0]  drop;
    logic        motor_ok;
    logic        load_ok;

    sfd_capture_ram #(
        .DEPTH (CapDepth),
        .AW    (CapAw)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx.rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rx.ready = (state_reg == ST_IDLE);
    assign accept   = rx.valid && rx.ready;

    assign widx      = {1'b0, bp_reg} + 16'd3;
    assign body_end  = ({1'b0, bp_reg} + 16'd1) >= {1'b0, len_reg};
    assign ram_we    = accept && (phase_reg == PH_BODY)
                       && (widx >= 16'(sfd_pkg::CAP_FIRST)) && (widx <= 16'(CapLast));
    assign ram_waddr = CapAw'(bp_reg - 15'd2);

    assign lenw    = {q_reg[2], q_reg[1]};
    assign len_bad = q_reg[2][7] || (lenw[14:0] > max_reg);

    assign motor_ok = (ft_reg == sfd_pkg::TYPE_MOTOR) && (({1'b0, len_reg} + 16'd1) >= 16'(CapLast));
    assign load_ok  = (ft_reg == sfd_pkg::TYPE_LOAD)
                      && (({1'b0, len_reg} + 16'd1) >= 16'(sfd_pkg::LOAD_LAST));

    // field layout: byte offset in the frame and byte count minus one
    always_comb
    begin
        base  = OffW'(sfd_pkg::DATA_START) + (unit_reg ? OffW'(MOTOR_STRIDE) : '0);
        off   = OffW'(sfd_pkg::DATA_START);
        nb_m1 = 2'd0;
        unique case (kind_reg)
            sfd_pkg::KIND_MOTOR:
            begin
                if (fid_reg == 4'd0)
                begin
                    off = base;
                end
                else if (fid_reg <= 4'd4)
                begin
                    off   = base + OffW'(1) + (OffW'(fid_reg - 4'd1) << 2);
                    nb_m1 = 2'd3;
                end
                else
                begin
                    off = base + OffW'(fid_reg) + OffW'(12);
                end
            end
            sfd_pkg::KIND_LOAD:
            begin
                unique case (fid_reg)
                    4'd0: off = OffW'(6);
                    4'd1:
                    begin
                        off   = OffW'(7);
                        nb_m1 = 2'd1;
                    end
                    4'd2:
                    begin
                        off   = OffW'(9);
                        nb_m1 = 2'd1;
                    end
                    default: off = OffW'(11);
                endcase
            end
            default: off = base;
        endcase
    end

    assign ram_raddr = CapAw'(off + OffW'(k_reg) - OffW'(sfd_pkg::CAP_FIRST));

    always_comb
    begin
        unique case (nb_m1)
            2'd0:    value = {24'b0, acc_reg[7:0]};
            2'd1:    value = {{16{acc_reg[15]}}, acc_reg[15:0]};
            default: value = acc_reg;
        endcase
    end

    assign rec_last = (kind_reg == sfd_pkg::KIND_NOTICE)
                      || ((kind_reg == sfd_pkg::KIND_LOAD) && (fid_reg == sfd_pkg::LOAD_LAST_FIELD))
                      || ((kind_reg == sfd_pkg::KIND_MOTOR)
                          && (fid_reg == sfd_pkg::MOTOR_LAST_FIELD)
                          && (unit_reg == 1'(MOTOR_UNITS - 1)));

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || rec.ready);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        bp_next    = bp_reg;
        len_next   = len_reg;
        ft_next    = ft_reg;
        rw_next    = rw_reg;
        q_next     = q_reg;
        n_next     = n_reg;
        kind_next  = kind_reg;
        unit_next  = unit_reg;
        fid_next   = fid_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        drop       = 2'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (phase_reg == PH_BODY)
                    begin
                        if (widx == 16'(sfd_pkg::CAP_FIRST))
                        begin
                            ft_next = rx.rx_byte;
                        end
                        if (body_end)
                        begin
                            q_next[0]  = rx.rx_byte;
                            n_next     = 3'd1;
                            phase_next = PH_HUNT;
                            bp_next    = '0;
                            state_next = (rx.rx_byte == sfd_pkg::TRL_BYTE) ? ST_START : ST_SCAN;
                        end
                        else
                        begin
                            bp_next = bp_reg + 15'd1;
                        end
                    end
                    else if (phase_reg == PH_HDR)
                    begin
                        q_next[0] = sfd_pkg::HDR_BYTE;
                        q_next[1] = rw_reg[0];
                        q_next[2] = rw_reg[1];
                        if (bp_reg == 15'd0)
                        begin
                            q_next[1] = rx.rx_byte;
                            n_next    = 3'd2;
                        end
                        else if (bp_reg == 15'd1)
                        begin
                            q_next[2] = rx.rx_byte;
                            n_next    = 3'd3;
                        end
                        else
                        begin
                            q_next[3] = rx.rx_byte;
                            n_next    = 3'd4;
                        end
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        q_next[0]  = rx.rx_byte;
                        n_next     = 3'd1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if ((n_reg != 3'd0) && (q_reg[0] != sfd_pkg::HDR_BYTE))
                begin
                    drop = 2'd1;
                end
                else if (n_reg < 3'd4)
                begin
                    if (n_reg != 3'd0)
                    begin
                        phase_next = PH_HDR;
                        bp_next    = 15'(n_reg - 3'd1);
                        rw_next[0] = q_reg[1];
                        rw_next[1] = q_reg[2];
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        bp_next    = '0;
                    end
                    state_next = ST_IDLE;
                end
                else if (len_bad)
                begin
                    drop = 2'd1;
                end
                else if (lenw[14:0] <= 15'd1)
                begin
                    // short frame fits in the window; resume at its last byte
                    ft_next  = '0;
                    len_next = lenw[14:0];
                    if (lenw[0])
                    begin
                        drop = 2'd3;
                        if (q_reg[3] == sfd_pkg::TRL_BYTE)
                        begin
                            state_next = ST_START;
                        end
                    end
                    else
                    begin
                        drop = 2'd2;
                        if (q_reg[2] == sfd_pkg::TRL_BYTE)
                        begin
                            state_next = ST_START;
                        end
                    end
                end
                else
                begin
                    len_next   = lenw[14:0];
                    ft_next    = '0;
                    bp_next    = 15'd1;
                    phase_next = PH_BODY;
                    n_next     = '0;
                    state_next = ST_IDLE;
                end

                unique case (drop)
                    2'd1:
                    begin
                        q_next[0] = q_reg[1];
                        q_next[1] = q_reg[2];
                        q_next[2] = q_reg[3];
                        n_next    = n_reg - 3'd1;
                    end
                    2'd2:
                    begin
                        q_next[0] = q_reg[2];
                        q_next[1] = q_reg[3];
                        n_next    = n_reg - 3'd2;
                    end
                    2'd3:
                    begin
                        q_next[0] = q_reg[3];
                        n_next    = n_reg - 3'd3;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_START:
            begin
                unit_next = 1'b0;
                fid_next  = '0;
                k_next    = '0;
                if (motor_ok)
                begin
                    kind_next  = sfd_pkg::KIND_MOTOR;
                    state_next = ST_RD;
                end
                else if (load_ok)
                begin
                    kind_next  = sfd_pkg::KIND_LOAD;
                    state_next = ST_RD;
                end
                else
                begin
                    kind_next  = sfd_pkg::KIND_NOTICE;
                    acc_next   = {24'b0, ft_reg};
                    state_next = ST_OUT;
                end
            end
            ST_RD:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next[k_reg*8 +: 8] = ram_rdata;
                if (k_reg == nb_m1)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_RD;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    k_next = '0;
                    if (rec_last)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RD;
                        if ((kind_reg == sfd_pkg::KIND_MOTOR) && (fid_reg == sfd_pkg::MOTOR_LAST_FIELD))
                        begin
                            fid_next  = '0;
                            unit_next = 1'b1;
                        end
                        else
                        begin
                            fid_next = fid_reg + 4'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rec.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_HUNT;
            bp_reg        <= '0;
            len_reg       <= '0;
            ft_reg        <= '0;
            max_reg       <= sfd_pkg::MAX_LEN_RESET;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bp_reg        <= bp_next;
            len_reg       <= len_next;
            ft_reg        <= ft_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rw_reg   <= rw_next;
        q_reg    <= q_next;
        kind_reg <= kind_next;
        unit_reg <= unit_next;
        fid_reg  <= fid_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        if (out_load)
        begin
            out_kind_reg  <= kind_reg;
            out_unit_reg  <= unit_reg;
            out_fid_reg   <= fid_reg;
            out_value_reg <= value;
            out_last_reg  <= rec_last;
        end
    end

    assign rec.valid         = out_valid_reg;
    assign rec.record_kind   = out_kind_reg;
    assign rec.unit_index    = out_unit_reg;
    assign rec.field_id      = out_fid_reg;
    assign rec.field_value   = out_value_reg;
    assign rec.last_of_frame = out_last_reg;

    a_hdr_held: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR) |-> (bp_reg <= 15'd2))
        else $error("header phase holds more than two bytes");

    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (n_reg <= 3'd4))
        else $error("scan window overflow");

    a_notice_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == sfd_pkg::KIND_NOTICE)) |-> out_last_reg)
        else $error("frame-only notice not marked last");

endmodule

@@ rtl/sfd_capture_ram.sv @@
module sfd_capture_ram #(
    parameter int DEPTH = 61,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
